// ===== design/command_frame_deframer_assert.svh =====
// ---------------------------------------------------------------------------
// Command frame deframer assertion macros
// Shared macros for the concurrent checks in the deframer modules.
// ---------------------------------------------------------------------------
`ifndef COMMAND_FRAME_DEFRAMER_ASSERT_SVH
`define COMMAND_FRAME_DEFRAMER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CFD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/cfd_pkg.sv =====
// ---------------------------------------------------------------------------
// Command frame deframer package
// Types and constants shared by the deframer modules.
// ---------------------------------------------------------------------------
`default_nettype none

package cfd_pkg;

   localparam int CFD_MAX_FRAME_BYTES = 4096;
   localparam logic [7:0] CFD_WIDE_CMD_RESET = 8'h44;
   localparam int CFD_POSITION_WIDTH = 13;
   localparam int CFD_POSITION_MAX = 8191;

   typedef enum logic [2:0] {
      ROLE_START  = 3'd0,
      ROLE_CMD    = 3'd1,
      ROLE_COUNT  = 3'd2,
      ROLE_LENHI  = 3'd3,
      ROLE_LENLO  = 3'd4,
      ROLE_DATA   = 3'd5,
      ROLE_END    = 3'd6
   } cfd_role_type;

   typedef struct packed {
      logic [7:0]                    data_byte;
      cfd_role_type                  byte_role;
      logic [7:0]                    param_number;
      logic                          wide_lengths;
      logic [CFD_POSITION_WIDTH-1:0] frame_position;
      logic                          frame_overflow;
      logic                          frame_end;
   } cfd_result_type;

endpackage

`default_nettype wire

// ===== design/command_frame_deframer.sv =====
// ---------------------------------------------------------------------------
// Command frame deframer
// Tags each received command-frame byte with its role and frame position.
// ---------------------------------------------------------------------------
// Bytes enter on the req_ channel, one per item, and every byte yields one
// tagged item on the rsp_ channel carrying the byte, its role, the parameter
// it belongs to, the frame's length width, its offset and the overflow and end flags.
// An item is taken when valid is high and stall is low on its channel.
// The csr_ channel writes the wide-length command byte; it is always ready
// and should only be written while no item is in flight.
// An accepted byte waits in the input register, is parsed, and is then held in
// the result register. Throughput is one item per cycle while the receiver
// does not stall; the frame state update is a single step.
// When the receiver stalls, the result register holds its item; an empty
// input register takes one more byte, and req_stall is high while both are full.
// Reset returns the parser to expecting a start byte, clears the frame
// offset, empties both registers and restores the wide command to 0x44.
// ---------------------------------------------------------------------------
`default_nettype none

`include "command_frame_deframer_assert.svh"

module command_frame_deframer #(
   parameter int MAX_FRAME_BYTES = cfd_pkg::CFD_MAX_FRAME_BYTES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_data_byte,
   output logic [2:0]       rsp_byte_role,
   output logic [7:0]       rsp_param_number,
   output logic             rsp_wide_lengths,
   output logic [12:0]      rsp_frame_position,
   output logic             rsp_frame_overflow,
   output logic             rsp_frame_end,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_wide_length_command
);

   localparam int POSITION_LIMIT = (MAX_FRAME_BYTES > cfd_pkg::CFD_POSITION_MAX) ?
                                   cfd_pkg::CFD_POSITION_MAX : MAX_FRAME_BYTES;

   logic                    in_ready;
   logic                    held_valid;
   logic [7:0]              held_byte;
   logic                    advance;
   cfd_pkg::cfd_result_type parsed;
   cfd_pkg::cfd_result_type out_item;

   assign csr_ready = 1'b1;
   assign req_stall = !in_ready;

   cfd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_byte    (req_rx_byte),
      .in_ready   (in_ready),
      .advance    (advance),
      .held_valid (held_valid),
      .held_byte  (held_byte)
   );

   cfd_parser #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg_write (csr_valid && csr_ready),
      .cfg_data  (csr_wide_length_command),
      .advance   (advance),
      .rx_byte   (held_byte),
      .result    (parsed)
   );

   cfd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .item_valid (held_valid),
      .item       (parsed),
      .advance    (advance),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_item   (out_item)
   );

   assign rsp_data_byte      = out_item.data_byte;
   assign rsp_byte_role      = out_item.byte_role;
   assign rsp_param_number   = out_item.param_number;
   assign rsp_wide_lengths   = out_item.wide_lengths;
   assign rsp_frame_position = out_item.frame_position;
   assign rsp_frame_overflow = out_item.frame_overflow;
   assign rsp_frame_end      = out_item.frame_end;

   `CFD_ASSERT_SAME(a_end_role, clock, reset,
      rsp_valid && rsp_frame_end, rsp_byte_role == cfd_pkg::ROLE_END,
      "end flag on a byte that is not the end byte")
   `CFD_ASSERT_SAME(a_overflow_position, clock, reset,
      rsp_valid && rsp_frame_overflow, rsp_frame_position == 13'(POSITION_LIMIT),
      "overflow reported below the buffer size")

endmodule

`default_nettype wire

// ===== design/cfd_in_reg.sv =====
// ---------------------------------------------------------------------------
// Command frame deframer input register
// Holds one received byte until the parse stage takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module cfd_in_reg (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   input  wire logic [7:0] in_byte,
   output logic            in_ready,
   input  wire logic       advance,
   output logic            held_valid,
   output logic [7:0]      held_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic       load;

   always_comb begin
      in_ready = !valid_ff || advance;
      load     = in_valid && in_ready;
      valid_in = load || (valid_ff && !advance);
      byte_in  = load ? in_byte : byte_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

endmodule

`default_nettype wire

// ===== design/cfd_parser.sv =====
// ---------------------------------------------------------------------------
// Command frame deframer parser
// Tags each byte with its role in the frame and tracks the frame state.
// ---------------------------------------------------------------------------
`default_nettype none

`include "command_frame_deframer_assert.svh"

module cfd_parser #(
   parameter int MAX_FRAME_BYTES = cfd_pkg::CFD_MAX_FRAME_BYTES
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           cfg_write,
   input  wire logic [7:0]     cfg_data,
   input  wire logic           advance,
   input  wire logic [7:0]     rx_byte,
   output cfd_pkg::cfd_result_type result
);

   localparam int OFFSET_WIDTH = $clog2(MAX_FRAME_BYTES + 1);
   localparam int EXT_WIDTH = cfd_pkg::CFD_POSITION_WIDTH + 1;

   logic [7:0]              wide_cmd_ff;
   cfd_pkg::cfd_role_type   phase_ff;
   cfd_pkg::cfd_role_type   phase_in;
   logic                    wide_ff;
   logic                    wide_in;
   logic [7:0]              remain_ff;
   logic [7:0]              remain_in;
   logic [7:0]              index_ff;
   logic [7:0]              index_in;
   logic [7:0]              lenhi_ff;
   logic [7:0]              lenhi_in;
   logic [15:0]             left_ff;
   logic [15:0]             left_in;
   logic [OFFSET_WIDTH-1:0] offset_ff;
   logic [OFFSET_WIDTH-1:0] offset_in;
   logic [EXT_WIDTH-1:0]    offset_ext;
   logic [15:0]             len;
   logic [15:0]             left_dec;
   logic [7:0]              remain_dec;
   cfd_pkg::cfd_role_type   after_param;
   logic                    finish;

   always_comb begin
      phase_in   = phase_ff;
      wide_in    = wide_ff;
      remain_in  = remain_ff;
      index_in   = index_ff;
      lenhi_in   = lenhi_ff;
      left_in    = left_ff;
      finish     = 1'b0;
      len        = wide_ff ? {lenhi_ff, rx_byte} : {8'd0, rx_byte};
      left_dec   = left_ff - 16'd1;
      remain_dec = remain_ff - 8'd1;
      after_param = wide_ff ? cfd_pkg::ROLE_LENHI : cfd_pkg::ROLE_LENLO;
      offset_ext = EXT_WIDTH'(offset_ff);

      result.data_byte      = rx_byte;
      result.byte_role      = phase_ff;
      result.param_number   = 8'd0;
      result.frame_end      = 1'b0;
      result.frame_overflow = (offset_ff >= OFFSET_WIDTH'(MAX_FRAME_BYTES));
      result.frame_position = (offset_ext > EXT_WIDTH'(cfd_pkg::CFD_POSITION_MAX)) ?
                              cfd_pkg::CFD_POSITION_WIDTH'(cfd_pkg::CFD_POSITION_MAX) :
                              offset_ext[cfd_pkg::CFD_POSITION_WIDTH-1:0];

      offset_in = result.frame_overflow ? offset_ff : offset_ff + OFFSET_WIDTH'(1);

      unique case (phase_ff)
         cfd_pkg::ROLE_START: begin
            wide_in   = 1'b0;
            remain_in = 8'd0;
            index_in  = 8'd0;
            lenhi_in  = 8'd0;
            left_in   = 16'd0;
            phase_in  = cfd_pkg::ROLE_CMD;
         end
         cfd_pkg::ROLE_CMD: begin
            wide_in  = (rx_byte == wide_cmd_ff);
            phase_in = cfd_pkg::ROLE_COUNT;
         end
         cfd_pkg::ROLE_COUNT: begin
            remain_in = rx_byte;
            index_in  = 8'd0;
            phase_in  = (rx_byte == 8'd0) ? cfd_pkg::ROLE_END : after_param;
         end
         cfd_pkg::ROLE_LENHI: begin
            result.param_number = index_ff;
            lenhi_in = rx_byte;
            phase_in = cfd_pkg::ROLE_LENLO;
         end
         cfd_pkg::ROLE_LENLO: begin
            result.param_number = index_ff;
            if (len == 16'd0) begin
               finish = 1'b1;
            end else begin
               left_in  = len;
               phase_in = cfd_pkg::ROLE_DATA;
            end
         end
         cfd_pkg::ROLE_DATA: begin
            result.param_number = index_ff;
            left_in = left_dec;
            finish  = (left_dec == 16'd0);
         end
         default: begin
            result.byte_role = cfd_pkg::ROLE_END;
            result.frame_end = 1'b1;
            phase_in  = cfd_pkg::ROLE_START;
            offset_in = '0;
         end
      endcase

      if (finish) begin
         remain_in = remain_dec;
         index_in  = index_ff + 8'd1;
         phase_in  = (remain_dec == 8'd0) ? cfd_pkg::ROLE_END : after_param;
      end

      result.wide_lengths = wide_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_cmd_ff <= cfd_pkg::CFD_WIDE_CMD_RESET;
         phase_ff    <= cfd_pkg::ROLE_START;
         wide_ff     <= 1'b0;
         remain_ff   <= 8'd0;
         index_ff    <= 8'd0;
         lenhi_ff    <= 8'd0;
         left_ff     <= 16'd0;
         offset_ff   <= '0;
      end else begin
         if (cfg_write) begin
            wide_cmd_ff <= cfg_data;
         end
         if (advance) begin
            phase_ff  <= phase_in;
            wide_ff   <= wide_in;
            remain_ff <= remain_in;
            index_ff  <= index_in;
            lenhi_ff  <= lenhi_in;
            left_ff   <= left_in;
            offset_ff <= offset_in;
         end
      end
   end

   `CFD_ASSERT_SAME(a_data_left_nonzero, clock, reset,
      phase_ff == cfd_pkg::ROLE_DATA, left_ff != 16'd0, "data phase with no bytes left")
   `CFD_ASSERT_SAME(a_lenhi_only_wide, clock, reset,
      phase_ff == cfd_pkg::ROLE_LENHI, wide_ff, "high length byte in a narrow frame")

endmodule

`default_nettype wire

// ===== design/cfd_out_reg.sv =====
// ---------------------------------------------------------------------------
// Command frame deframer result register
// Holds one tagged item until the receiver takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module cfd_out_reg (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    item_valid,
   input  wire cfd_pkg::cfd_result_type item,
   output logic                         advance,
   output logic                         out_valid,
   input  wire logic                    out_stall,
   output cfd_pkg::cfd_result_type      out_item
);

   logic                    valid_ff;
   logic                    valid_in;
   cfd_pkg::cfd_result_type item_ff;
   cfd_pkg::cfd_result_type item_in;

   always_comb begin
      advance  = item_valid && (!valid_ff || !out_stall);
      valid_in = advance || (valid_ff && out_stall);
      item_in  = advance ? item : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire
